### rtl/chtab_pkg.sv
// ----------------------------------------------------------------------------
// Hash table package
// Shared constants, operation and status codes, and the control interface
// types that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package chtab_pkg;

    localparam int MAX_BUCKETS_DEF = 256;
    localparam int POOL_NODES_DEF  = 1024;

    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 9;

    localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 9'd256;

    // The remainder unit retires this many key bits per cycle.
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = KEY_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic                clr_wr;
        logic                capture;
        logic                div_step;
        logic                head_rd;
        logic                walk_init;
        logic                node_rd;
        logic                walk_adv;
        logic                alloc_rd;
        logic                ins_commit;
        logic                ins_from_free;
        logic                save_next;
        logic                unlink;
        logic                relink;
        logic                set_res;
        logic [STATUS_W-1:0] res_status;
        logic                res_use_val;
        logic                load_out;
    } chtab_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            p_valid;
        logic            steps_done;
        logic            match;
        logic            free_valid;
        logic            fresh_avail;
        logic            prev_valid;
        logic            clr_last;
    } chtab_stat_t;

endpackage

### rtl/chtab_if.sv
// ----------------------------------------------------------------------------
// Hash table channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface chtab_req_if
    import chtab_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;

    modport source (output valid, output opcode, output key, output value, input ready);
    modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

interface chtab_rsp_if
    import chtab_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    found_value;

    modport source (output valid, output status, output found_value, input ready);
    modport sink   (input valid, input status, input found_value, output ready);
endinterface

### rtl/chtab_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module chtab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/chtab_dp.sv
// ----------------------------------------------------------------------------
// Hash table datapath
// Bucket remainder unit, chain walk registers, node pool and head memories.
// ----------------------------------------------------------------------------
module chtab_dp
    import chtab_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int POOL_NODES  = POOL_NODES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic [OP_W-1:0]     in_opcode,
    input  logic [KEY_W-1:0]    in_key,
    input  logic [VAL_W-1:0]    in_value,
    input  chtab_cmd_t          cmd,
    output chtab_stat_t         stat,
    output logic [STATUS_W-1:0] out_status,
    output logic [VAL_W-1:0]    out_value
);

    localparam int PW = $clog2(POOL_NODES + 1);
    localparam int AW = $clog2(POOL_NODES);
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam logic [PW-1:0] NIL = PW'(POOL_NODES);

    logic [CFG_W-1:0]    bc_reg;
    logic [CFG_W-1:0]    n_reg, n_next;
    logic [CFG_W-1:0]    rem_reg, rem_next;
    logic [KEY_W-1:0]    sh_reg;
    logic [OP_W-1:0]     op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VAL_W-1:0]    val_reg;
    logic [PW-1:0]       p_reg, prev_reg, steps_reg, head_reg, next_reg;
    logic [PW-1:0]       free_reg, fresh_reg;
    logic [BW-1:0]       clr_reg;
    logic [STATUS_W-1:0] res_status_reg, out_status_reg;
    logic [VAL_W-1:0]    res_val_reg, out_val_reg;

    logic [BW-1:0]    bucket;
    logic [PW-1:0]    new_node;
    logic [PW-1:0]    head_rdata, link_rdata;
    logic [KEY_W-1:0] key_rdata;
    logic [VAL_W-1:0] val_rdata;

    logic            head_we;
    logic [BW-1:0]   head_waddr;
    logic [PW-1:0]   head_wdata;
    logic            link_we;
    logic [AW-1:0]   link_waddr;
    logic [PW-1:0]   link_wdata;
    logic [AW-1:0]   link_raddr;

    // Effective divisor: zero acts as one, large values saturate.
    always_comb
    begin
        if (bc_reg == '0)
        begin
            n_next = CFG_W'(1);
        end
        else if (17'(bc_reg) > 17'(MAX_BUCKETS))
        begin
            n_next = CFG_W'(MAX_BUCKETS);
        end
        else
        begin
            n_next = bc_reg;
        end
    end

    // Restoring remainder, DIV_BITS key bits per cycle.
    always_comb
    begin
        logic [CFG_W:0] t;
        logic [CFG_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            t = {r, sh_reg[KEY_W-1-i]};
            if (t >= {1'b0, n_reg})
            begin
                r = CFG_W'(t - {1'b0, n_reg});
            end
            else
            begin
                r = t[CFG_W-1:0];
            end
        end
        rem_next = r;
    end

    assign bucket   = BW'(rem_reg);
    assign new_node = cmd.ins_from_free ? free_reg : fresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg    <= BUCKET_COUNT_RST;
            free_reg  <= NIL;
            fresh_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                bc_reg <= cfg_wdata;
            end
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + BW'(1);
            end
            if (cmd.ins_commit)
            begin
                if (cmd.ins_from_free)
                begin
                    free_reg <= link_rdata;
                end
                else
                begin
                    fresh_reg <= fresh_reg + PW'(1);
                end
            end
            if (cmd.relink)
            begin
                free_reg <= p_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_opcode;
            key_reg <= in_key;
            val_reg <= in_value;
            sh_reg  <= in_key;
            rem_reg <= '0;
            n_reg   <= n_next;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            sh_reg  <= sh_reg << DIV_BITS;
        end
        if (cmd.walk_init)
        begin
            head_reg  <= head_rdata;
            p_reg     <= head_rdata;
            prev_reg  <= NIL;
            steps_reg <= '0;
        end
        if (cmd.walk_adv)
        begin
            prev_reg  <= p_reg;
            p_reg     <= link_rdata;
            steps_reg <= steps_reg + PW'(1);
        end
        if (cmd.save_next)
        begin
            next_reg <= link_rdata;
        end
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_status;
            res_val_reg    <= cmd.res_use_val ? val_rdata : '0;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_val_reg    <= res_val_reg;
        end
    end

    assign head_we    = cmd.clr_wr | cmd.ins_commit | (cmd.unlink & ~stat.prev_valid);
    assign head_waddr = cmd.clr_wr ? clr_reg : bucket;
    assign head_wdata = cmd.clr_wr ? NIL : (cmd.ins_commit ? new_node : next_reg);

    assign link_we = cmd.ins_commit | (cmd.unlink & stat.prev_valid) | cmd.relink;

    always_comb
    begin
        if (cmd.ins_commit)
        begin
            link_waddr = new_node[AW-1:0];
            link_wdata = head_reg;
        end
        else if (cmd.unlink)
        begin
            link_waddr = prev_reg[AW-1:0];
            link_wdata = next_reg;
        end
        else
        begin
            link_waddr = p_reg[AW-1:0];
            link_wdata = free_reg;
        end
    end

    assign link_raddr = cmd.alloc_rd ? free_reg[AW-1:0] : p_reg[AW-1:0];

    chtab_ram #(.WIDTH(PW), .DEPTH(MAX_BUCKETS)) u_heads (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (cmd.head_rd),
        .raddr (bucket),
        .rdata (head_rdata)
    );

    chtab_ram #(.WIDTH(KEY_W), .DEPTH(POOL_NODES)) u_keys (
        .clk   (clk),
        .we    (cmd.ins_commit),
        .waddr (new_node[AW-1:0]),
        .wdata (key_reg),
        .re    (cmd.node_rd),
        .raddr (p_reg[AW-1:0]),
        .rdata (key_rdata)
    );

    chtab_ram #(.WIDTH(VAL_W), .DEPTH(POOL_NODES)) u_values (
        .clk   (clk),
        .we    (cmd.ins_commit),
        .waddr (new_node[AW-1:0]),
        .wdata (val_reg),
        .re    (cmd.node_rd),
        .raddr (p_reg[AW-1:0]),
        .rdata (val_rdata)
    );

    chtab_ram #(.WIDTH(PW), .DEPTH(POOL_NODES)) u_links (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (cmd.node_rd | cmd.alloc_rd),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    assign stat.op          = op_reg;
    assign stat.p_valid     = p_reg < NIL;
    assign stat.steps_done  = steps_reg == NIL;
    assign stat.match       = key_rdata == key_reg;
    assign stat.free_valid  = free_reg < NIL;
    assign stat.fresh_avail = fresh_reg < NIL;
    assign stat.prev_valid  = prev_reg < NIL;
    assign stat.clr_last    = clr_reg == BW'(MAX_BUCKETS - 1);

    assign out_status = out_status_reg;
    assign out_value  = out_val_reg;

endmodule

### rtl/chtab_ctrl.sv
// ----------------------------------------------------------------------------
// Hash table controller
// Sequences the head clear, remainder, chain walk and list updates.
// ----------------------------------------------------------------------------
module chtab_ctrl
    import chtab_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  chtab_stat_t stat,
    output chtab_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_HEAD,
        S_HEADW,
        S_WALK,
        S_NODEW,
        S_ALLOCW,
        S_INSERT,
        S_UNLINK,
        S_RELINK,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                cmd.head_rd = 1'b1;
                state_next  = S_HEADW;
            end
            S_HEADW:
            begin
                cmd.walk_init = 1'b1;
                state_next    = S_WALK;
            end
            S_WALK:
            begin
                if (stat.p_valid && !stat.steps_done)
                begin
                    cmd.node_rd = 1'b1;
                    state_next  = S_NODEW;
                end
                else if (stat.op == OP_INSERT)
                begin
                    // Key absent: take a returned node first, then a fresh one.
                    if (stat.free_valid)
                    begin
                        cmd.alloc_rd = 1'b1;
                        state_next   = S_ALLOCW;
                    end
                    else if (stat.fresh_avail)
                    begin
                        state_next = S_INSERT;
                    end
                    else
                    begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = ST_FULL;
                        state_next     = S_DONE;
                    end
                end
                else
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_MISS;
                    state_next     = S_DONE;
                end
            end
            S_NODEW:
            begin
                if (!stat.match)
                begin
                    cmd.walk_adv = 1'b1;
                    state_next   = S_WALK;
                end
                else if (stat.op == OP_FIND)
                begin
                    cmd.set_res     = 1'b1;
                    cmd.res_status  = ST_OK;
                    cmd.res_use_val = 1'b1;
                    state_next      = S_DONE;
                end
                else if (stat.op == OP_REMOVE)
                begin
                    cmd.save_next = 1'b1;
                    state_next    = S_UNLINK;
                end
                else
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_MISS;
                    state_next     = S_DONE;
                end
            end
            S_ALLOCW:
            begin
                cmd.ins_commit    = 1'b1;
                cmd.ins_from_free = 1'b1;
                cmd.set_res       = 1'b1;
                cmd.res_status    = ST_OK;
                state_next        = S_DONE;
            end
            S_INSERT:
            begin
                cmd.ins_commit = 1'b1;
                cmd.set_res    = 1'b1;
                cmd.res_status = ST_OK;
                state_next     = S_DONE;
            end
            S_UNLINK:
            begin
                cmd.unlink = 1'b1;
                state_next = S_RELINK;
            end
            S_RELINK:
            begin
                cmd.relink     = 1'b1;
                cmd.set_res    = 1'b1;
                cmd.res_status = ST_OK;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

### rtl/chained_hash_table_top.sv
// ----------------------------------------------------------------------------
// Chained hash table
// Key/value table with separate chaining over a fixed node pool.
// ----------------------------------------------------------------------------
// Requests (find, insert, remove on a 32-bit key) arrive on the req channel
// and each produces exactly one transfer on the rsp channel with a status
// and, for a successful find, the stored value.
// After reset the bucket heads are cleared one per cycle, during which no
// request is taken; the bucket_count register (cfg_we/cfg_wdata, reset 256)
// may be written at any idle time. One request at a time: the controller
// takes it, works out the bucket remainder (4 key bits per cycle), reads
// the bucket head, reads each chain node visited (one node memory read
// each), ends a walk that finds nothing, makes any list update and loads
// the result. The result sits in an output register; a stalled receiver
// holds it, and the next request is taken and worked on meanwhile,
// waiting only to deliver its own result.
// ----------------------------------------------------------------------------
module chained_hash_table_top
    import chtab_pkg::*;
#(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int POOL_NODES  = POOL_NODES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    chtab_req_if.sink        req,
    chtab_rsp_if.source      rsp
);

    chtab_cmd_t  cmd;
    chtab_stat_t stat;

    chtab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    chtab_dp #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .POOL_NODES  (POOL_NODES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_opcode  (req.opcode),
        .in_key     (req.key),
        .in_value   (req.value),
        .cmd        (cmd),
        .stat       (stat),
        .out_status (rsp.status),
        .out_value  (rsp.found_value)
    );

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// Chained hash table testbench
// Drives find, insert and remove requests with random gaps and response
// stalls, and predicts every response from a behavioral copy of the table.
// Covers chain ordering, free-list reuse, bucket count changes and a large
// batch of nodes freed again.
// ----------------------------------------------------------------------------
module tb;
    import chtab_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int NIL        = POOL_NODES_DEF;
    localparam int IDLE_LIMIT = 6000;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    found_value;
    } table_rsp_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    chtab_req_if req_ch();
    chtab_rsp_if rsp_ch();

    chained_hash_table_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Shadow copy of the table.
    logic [CFG_W-1:0] shadow_buckets;
    int               chain_head [MAX_BUCKETS_DEF];
    logic [KEY_W-1:0] node_key   [POOL_NODES_DEF];
    logic [VAL_W-1:0] node_val   [POOL_NODES_DEF];
    int               node_next  [POOL_NODES_DEF];
    int               free_list;
    int               fresh_used;

    table_rsp_t       pending_rsp [$];
    logic [KEY_W-1:0] key_set [48];
    int               mismatches;
    int               idle_cycles;
    bit               no_gaps;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int hash_bucket(logic [KEY_W-1:0] key);
        int n;
        n = int'(shadow_buckets);
        if (n == 0)
            n = 1;
        if (n > MAX_BUCKETS_DEF)
            n = MAX_BUCKETS_DEF;
        return key % n;
    endfunction

    function automatic table_rsp_t table_apply(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                               logic [VAL_W-1:0] value);
        table_rsp_t r;
        int b;
        int p;
        int prev;
        int n;
        r.status      = ST_MISS;
        r.found_value = '0;
        b    = hash_bucket(key);
        p    = chain_head[b];
        prev = NIL;
        while (p != NIL && node_key[p] != key)
        begin
            prev = p;
            p    = node_next[p];
        end
        if (op == OP_FIND && p != NIL)
        begin
            r.status      = ST_OK;
            r.found_value = node_val[p];
        end
        else if (op == OP_INSERT && p == NIL)
        begin
            n = NIL;
            if (free_list != NIL)
            begin
                n         = free_list;
                free_list = node_next[n];
            end
            else if (fresh_used < POOL_NODES_DEF)
            begin
                n = fresh_used;
                fresh_used++;
            end
            if (n != NIL)
            begin
                node_key[n]   = key;
                node_val[n]   = value;
                node_next[n]  = chain_head[b];
                chain_head[b] = n;
                r.status      = ST_OK;
            end
            else
                r.status = ST_FULL;
        end
        else if (op == OP_REMOVE && p != NIL)
        begin
            if (prev != NIL)
                node_next[prev] = node_next[p];
            else
                chain_head[b] = node_next[p];
            node_next[p] = free_list;
            free_list    = p;
            r.status     = ST_OK;
        end
        return r;
    endfunction

    function automatic int draw_gap();
        if (no_gaps)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    // Sends one request; valid stays high after the transfer so that a
    // back-to-back request needs no second assignment in the same step.
    task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                logic [VAL_W-1:0] value);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= op;
        req_ch.key    <= key;
        req_ch.value  <= value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_rsp.push_back(table_apply(op, key, value));
    endtask

    // Waits for every outstanding response, then writes the bucket count.
    task automatic set_bucket_count(logic [CFG_W-1:0] count);
        if (req_ch.valid)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(posedge clk);
        cfg_we         <= 1'b0;
        shadow_buckets = count;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) < 7)
            return key_set[$urandom_range(0, 47)];
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 39);
        if (r == 0)
            return OP_UNUSED;
        if (r < 14)
            return OP_FIND;
        if (r < 28)
            return OP_INSERT;
        return OP_REMOVE;
    endfunction

    task automatic test_basic_ops();
        send_request(OP_FIND,   32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 32'h0000_0000, 32'h0);
        send_request(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_INSERT, 32'h0000_0000, 32'h1234_5678);
        send_request(OP_FIND,   32'h0000_0000, 32'h0);
        send_request(OP_FIND,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_FIND,   32'h0000_0100, 32'h0);
        send_request(OP_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 32'h0000_0000, 32'h0);
        send_request(OP_FIND,   32'h0000_0000, 32'h0);
    endtask

    // One bucket puts every key on a single chain: middle and tail
    // removal, then reuse of the freed nodes.
    task automatic test_single_chain();
        set_bucket_count(9'd1);
        send_request(OP_INSERT, 32'h8000_0000, 32'hA5A5_A5A5);
        send_request(OP_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
        send_request(OP_INSERT, 32'h0000_0001, 32'h0000_0011);
        send_request(OP_REMOVE, 32'h7FFF_FFFF, 32'h0);
        send_request(OP_REMOVE, 32'h8000_0000, 32'h0);
        send_request(OP_FIND,   32'h0000_0001, 32'h0);
        send_request(OP_INSERT, 32'h0000_0002, 32'hDEAD_BEEF);
        send_request(OP_INSERT, 32'h0000_0003, 32'hCAFE_F00D);
        send_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_FIND,   32'h0000_0002, 32'h0);
    endtask

    // Count changes with entries stored; zero acts as one, large values
    // saturate to the maximum.
    task automatic test_bucket_extremes();
        set_bucket_count(9'd0);
        send_request(OP_FIND, 32'h0000_0002, 32'h0);
        set_bucket_count(9'h1FF);
        send_request(OP_FIND, 32'h0000_0002, 32'h0);
        send_request(OP_INSERT, 32'h0000_01FF, 32'h0000_0001);
        set_bucket_count(9'd257);
        send_request(OP_FIND, 32'h0000_01FF, 32'h0);
        set_bucket_count(9'd3);
        send_request(OP_FIND, 32'h0000_0003, 32'h0);
    endtask

    task automatic test_random_mix(int count);
        logic [CFG_W-1:0] settings [5];
        settings = '{9'd256, 9'd1, 9'd7, 9'd100, 9'd0};
        settings[4] = CFG_W'($urandom_range(1, 511));
        for (int s = 0; s < 5; s++)
        begin
            set_bucket_count(settings[s]);
            for (int i = 0; i < count / 5; i++)
            begin
                if (i % 40 == 0)
                    no_gaps = ($urandom_range(0, 2) == 0);
                send_request(pick_op(), pick_key(), $urandom);
            end
        end
        no_gaps = 1'b0;
    endtask

    // Takes a batch of nodes (returned ones first, then fresh ones), frees them
    // all again, then reuses the most recently freed node.
    task automatic test_pool_churn(int count);
        logic [KEY_W-1:0] base;
        base = 32'h4000_0000;
        set_bucket_count(9'd256);
        no_gaps = 1'b1;
        for (int i = 0; i < count; i++)
            send_request(OP_INSERT, base + KEY_W'(i), $urandom);
        send_request(OP_FIND, base, 32'h0);
        for (int i = 0; i < count; i++)
            send_request(OP_REMOVE, base + KEY_W'(i), 32'h0);
        send_request(OP_INSERT, base, 32'h0000_0042);
        send_request(OP_FIND, base, 32'h0);
        no_gaps = 1'b0;
    endtask

    // Response side: random stall before each transfer, checked in order.
    initial
    begin
        int stall;
        table_rsp_t want;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: status %0d value %h",
                             rsp_ch.status, rsp_ch.found_value);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_ch.status !== want.status || rsp_ch.found_value !== want.found_value)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("response mismatch: status %0d/%0d value %h/%h (exp/act)",
                                 want.status, rsp_ch.status, want.found_value,
                                 rsp_ch.found_value);
                end
            end
        end
    end

    // Watchdog over cycles without any transfer; reset clearing is included.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        req_ch.valid  <= 1'b0;
        req_ch.opcode <= OP_FIND;
        req_ch.key    <= '0;
        req_ch.value  <= '0;
        idle_cycles   = 0;
        mismatches    = 0;
        no_gaps       = 1'b0;
        shadow_buckets = BUCKET_COUNT_RST;
        for (int i = 0; i < MAX_BUCKETS_DEF; i++)
            chain_head[i] = NIL;
        free_list  = NIL;
        fresh_used = 0;
        key_set[0] = 32'h0000_0000;
        key_set[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 48; i++)
            key_set[i] = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 1023);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_single_chain();
        test_bucket_extremes();
        test_random_mix(420);
        test_pool_churn(100);

        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
